/* hw/rtl/btcs_pkg.sv */
// ----------------------------------------------------------------------------
// btcs_pkg: shared definitions for the balance and turn control step
// Number format, controller constants, datapath select codes, the command
// word from controller to datapath and the saturation helper.
// ----------------------------------------------------------------------------
package btcs_pkg;

  // Fixed point format: signed, FRAC_BITS fraction bits in a 32-bit word.
  localparam int FRAC_BITS = 20;
  localparam int DW        = 32;
  localparam int SW        = 26;
  localparam int OPW       = 35;
  localparam int KW        = (FRAC_BITS + 1 > 14) ? FRAC_BITS + 1 : 14;
  localparam int PW        = OPW + KW + 1;
  localparam int AW        = 50;

  localparam longint QONE     = longint'(1) << FRAC_BITS;
  localparam longint RND_HALF = longint'(1) << (FRAC_BITS - 1);
  localparam longint MAX32    = 64'sd2147483647;
  localparam longint MIN32    = -64'sd2147483648;

  // Fractional constants, rounded to nearest at FRAC_BITS.
  localparam longint K_INV_G      = (100 * QONE + 967 / 2) / 967;
  localparam longint K_ACC_BIAS   = (5 * QONE + 1000 / 2) / 1000;
  localparam longint K_ROLL_BIAS  = (76 * QONE + 1000 / 2) / 1000;
  localparam longint K_PITCH_BIAS = (2 * QONE + 100 / 2) / 100;
  localparam longint K_DT         = (5 * QONE + 1000 / 2) / 1000;
  localparam longint K_ALPHA      = (2 * QONE + 100 / 2) / 100;
  localparam longint K_KEEP       = (98 * QONE + 100 / 2) / 100;
  localparam longint K_SPD_P      = (2 * QONE + 1000 / 2) / 1000;
  localparam longint K_SPD_D      = (2 * QONE + 1000 / 2) / 1000;
  localparam longint K_REF_BIAS   = (4 * QONE + 1000 / 2) / 1000;
  localparam longint K_TILT_I     = (35 * QONE + 1000 / 2) / 1000;
  localparam longint K_TILT_WIN   = (2 * QONE + 100 / 2) / 100;

  // Integer loop gains.
  localparam longint GAIN_TILT_P = 2200;
  localparam longint GAIN_TILT_D = 12800;
  localparam longint GAIN_TURN_P = 10;
  localparam longint GAIN_TURN_D = 1600;

  // Configuration register indexes.
  localparam logic REG_SPEED_SETPOINT   = 1'b0;
  localparam logic REG_HEADING_SETPOINT = 1'b1;

  typedef enum logic [3:0] {
    OPA_ES, OPA_ES_MEM, OPA_AZ, OPA_PITCH, OPA_ACC_ANG, OPA_INNER,
    OPA_ROLL, OPA_DTILT, OPA_ERR, OPA_ERR_SUM, OPA_TERR, OPA_DHEAD
  } opa_sel_e;

  typedef enum logic [3:0] {
    KS_SPD_P, KS_SPD_D, KS_INV_G, KS_DT, KS_ALPHA, KS_KEEP, KS_TILT_I,
    KS_TILT_P, KS_TILT_D, KS_TURN_P, KS_TURN_D
  } k_sel_e;

  typedef enum logic [1:0] {
    BASE_ZERO, BASE_ACC, BASE_LAST_TILT, BASE_LAST_HEAD
  } base_sel_e;

  typedef enum logic [1:0] {
    BIAS_NONE, BIAS_REF, BIAS_ACC
  } bias_sel_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_REF, DST_ACC_ANG, DST_INNER, DST_TILT, DST_HEAD,
    DST_DRIVE, DST_TURN
  } dest_sel_e;

  typedef struct packed {
    logic      capture;
    logic      mem_upd;
    logic      mul_en;
    opa_sel_e  opa;
    k_sel_e    ksel;
    logic      acc_en;
    base_sel_e base;
    logic      p_sub;
    bias_sel_e bias;
    dest_sel_e dest;
    logic      out_load;
  } dp_cmd_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > AW'(MAX32)) begin
      r = DW'(MAX32);
    end else if (x < AW'(MIN32)) begin
      r = DW'(MIN32);
    end else begin
      r = DW'(x);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/btcs_ctrl.sv */
// ----------------------------------------------------------------------------
// btcs_ctrl: sequencer of the balance and turn control step
// Steps the datapath through the multiply and accumulate schedule of one
// tick and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module btcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output btcs_pkg::dp_cmd_t cmd_o
);
  import btcs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_e;

  localparam logic [3:0] LAST_STEP = 4'd12;

  state_e     state_q;
  logic [3:0] step_q;
  logic       out_valid_q;
  logic       out_free;

  // One entry per schedule step. The multiplier issues a product in the
  // step, and the accumulator consumes the product issued one step earlier.
  function automatic dp_cmd_t step_cmd(input logic [3:0] step);
    dp_cmd_t c;
    c = '0;
    c.mul_en = 1'b1;
    c.acc_en = 1'b1;
    case (step)
      4'd0: begin
        c.mem_upd = 1'b1;
        c.acc_en  = 1'b0;
        c.opa     = OPA_ES;
        c.ksel    = KS_SPD_P;
      end
      4'd1: begin
        c.opa  = OPA_ES_MEM;
        c.ksel = KS_SPD_D;
        c.base = BASE_ZERO;
      end
      4'd2: begin
        c.opa   = OPA_AZ;
        c.ksel  = KS_INV_G;
        c.base  = BASE_ACC;
        c.p_sub = 1'b1;
        c.bias  = BIAS_REF;
        c.dest  = DST_REF;
      end
      4'd3: begin
        c.opa  = OPA_PITCH;
        c.ksel = KS_DT;
        c.base = BASE_ZERO;
        c.bias = BIAS_ACC;
        c.dest = DST_ACC_ANG;
      end
      4'd4: begin
        c.opa  = OPA_ACC_ANG;
        c.ksel = KS_ALPHA;
        c.base = BASE_LAST_TILT;
        c.dest = DST_INNER;
      end
      4'd5: begin
        c.opa  = OPA_INNER;
        c.ksel = KS_KEEP;
        c.base = BASE_ZERO;
      end
      4'd6: begin
        c.opa  = OPA_ROLL;
        c.ksel = KS_DT;
        c.base = BASE_ACC;
        c.dest = DST_TILT;
      end
      4'd7: begin
        c.opa  = OPA_DTILT;
        c.ksel = KS_TILT_D;
        c.base = BASE_LAST_HEAD;
        c.dest = DST_HEAD;
      end
      4'd8: begin
        c.opa   = OPA_ERR;
        c.ksel  = KS_TILT_P;
        c.base  = BASE_ZERO;
        c.p_sub = 1'b1;
      end
      4'd9: begin
        c.opa  = OPA_ERR_SUM;
        c.ksel = KS_TILT_I;
        c.base = BASE_ACC;
      end
      4'd10: begin
        c.opa  = OPA_TERR;
        c.ksel = KS_TURN_P;
        c.base = BASE_ACC;
        c.dest = DST_DRIVE;
      end
      4'd11: begin
        c.opa  = OPA_DHEAD;
        c.ksel = KS_TURN_D;
        c.base = BASE_ZERO;
      end
      4'd12: begin
        c.mul_en = 1'b0;
        c.base   = BASE_ACC;
        c.dest   = DST_TURN;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In the finish state the load below decides the valid flag.
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            step_q  <= '0;
          end
        end
        ST_RUN: begin
          if (step_q == LAST_STEP) begin
            state_q <= ST_FINISH;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.capture  = in_valid_i;
      ST_RUN:    cmd_o          = step_cmd(step_q);
      ST_FINISH: cmd_o.out_load = out_free;
      default:   cmd_o          = '0;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/btcs_datapath.sv */
// ----------------------------------------------------------------------------
// btcs_datapath: arithmetic of the balance and turn control step
// Holds the setpoints, loop state and intermediate values, one shared
// multiplier with rounding, an accumulator and the output word register.
// ----------------------------------------------------------------------------
module btcs_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  btcs_pkg::dp_cmd_t                cmd_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [btcs_pkg::DW-1:0]          cfg_data_i,
  input  logic signed [btcs_pkg::DW-1:0]   accel_vertical_i,
  input  logic signed [btcs_pkg::DW-1:0]   roll_rate_i,
  input  logic signed [btcs_pkg::DW-1:0]   pitch_rate_i,
  input  logic signed [btcs_pkg::DW-1:0]   wheel_speed_i,
  output logic signed [btcs_pkg::DW-1:0]   left_accel_o,
  output logic signed [btcs_pkg::DW-1:0]   right_accel_o,
  output logic                             drive_positive_o,
  output logic signed [btcs_pkg::DW-1:0]   tilt_estimate_o,
  output logic signed [btcs_pkg::DW-1:0]   heading_estimate_o
);
  import btcs_pkg::*;

  logic signed [SW-1:0]  spd_sp_q;
  logic signed [DW-1:0]  head_sp_q;
  logic signed [DW-1:0]  last_tilt_q, last_head_q, mem_q;
  logic signed [DW-1:0]  az_q, roll_q, pitch_q, ws_q;
  logic signed [DW-1:0]  ref_q, acc_ang_q, inner_q, tilt_q, head_q, drive_q, turn_q;
  logic signed [PW-1:0]  prod_q;
  logic                  frac_q;
  logic signed [AW-1:0]  acc_q;

  logic signed [OPW-1:0] opa;
  logic [KW-1:0]         kval;
  logic                  k_frac;
  logic signed [PW-1:0]  prod_rnd;
  logic signed [AW-1:0]  p_term, base_val, bias_val, acc_d;
  logic signed [DW-1:0]  acc_sat;
  logic signed [AW-1:0]  drv_ext, trn_ext;
  logic                  tilt_in_win;
  logic signed [DW-1:0]  left_d, right_d;

  // Configuration and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_sp_q    <= '0;
      head_sp_q   <= '0;
      last_tilt_q <= '0;
      last_head_q <= '0;
      mem_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPEED_SETPOINT:   spd_sp_q  <= cfg_data_i[SW-1:0];
          REG_HEADING_SETPOINT: head_sp_q <= cfg_data_i;
          default: ;
        endcase
      end
      // The speed error register follows its recurrence before use.
      if (cmd_i.mem_upd) begin
        mem_q <= sat32(AW'(spd_sp_q) - AW'(mem_q));
      end
      if (cmd_i.out_load) begin
        last_tilt_q <= tilt_q;
        last_head_q <= head_q;
      end
    end
  end

  always_comb begin
    case (cmd_i.opa)
      OPA_ES:      opa = OPW'(spd_sp_q) - OPW'(ws_q);
      OPA_ES_MEM:  opa = OPW'(spd_sp_q) - OPW'(ws_q) - OPW'(mem_q);
      OPA_AZ:      opa = OPW'(az_q);
      OPA_PITCH:   opa = OPW'(pitch_q) - OPW'(K_PITCH_BIAS);
      OPA_ACC_ANG: opa = OPW'(acc_ang_q);
      OPA_INNER:   opa = OPW'(inner_q);
      OPA_ROLL:    opa = OPW'(roll_q) + OPW'(K_ROLL_BIAS);
      OPA_DTILT:   opa = OPW'(last_tilt_q) - OPW'(tilt_q);
      OPA_ERR:     opa = OPW'(ref_q) - OPW'(tilt_q);
      OPA_ERR_SUM: opa = OPW'(ref_q) + OPW'(ref_q) - OPW'(tilt_q) - OPW'(last_tilt_q);
      OPA_TERR:    opa = OPW'(head_sp_q) - OPW'(head_q);
      OPA_DHEAD:   opa = OPW'(last_head_q) - OPW'(head_q);
      default:     opa = '0;
    endcase
  end

  always_comb begin
    k_frac = 1'b1;
    case (cmd_i.ksel)
      KS_SPD_P:  kval = KW'(K_SPD_P);
      KS_SPD_D:  kval = KW'(K_SPD_D);
      KS_INV_G:  kval = KW'(K_INV_G);
      KS_DT:     kval = KW'(K_DT);
      KS_ALPHA:  kval = KW'(K_ALPHA);
      KS_KEEP:   kval = KW'(K_KEEP);
      KS_TILT_I: kval = KW'(K_TILT_I);
      KS_TILT_P: begin
        kval   = KW'(GAIN_TILT_P);
        k_frac = 1'b0;
      end
      KS_TILT_D: begin
        kval   = KW'(GAIN_TILT_D);
        k_frac = 1'b0;
      end
      KS_TURN_P: begin
        kval   = KW'(GAIN_TURN_P);
        k_frac = 1'b0;
      end
      KS_TURN_D: begin
        kval   = KW'(GAIN_TURN_D);
        k_frac = 1'b0;
      end
      default:   kval = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PW'(opa) * PW'($signed({1'b0, kval}));
      frac_q <= k_frac;
    end
  end

  // Fractional products round to nearest with ties toward plus infinity.
  always_comb begin
    prod_rnd = prod_q + PW'(RND_HALF);
    p_term   = frac_q ? AW'(prod_rnd >>> FRAC_BITS) : AW'(prod_q);
    case (cmd_i.base)
      BASE_ZERO:      base_val = '0;
      BASE_ACC:       base_val = acc_q;
      BASE_LAST_TILT: base_val = AW'(last_tilt_q);
      BASE_LAST_HEAD: base_val = AW'(last_head_q);
      default:        base_val = '0;
    endcase
    case (cmd_i.bias)
      BIAS_REF: bias_val = AW'(K_REF_BIAS);
      BIAS_ACC: bias_val = AW'(K_ACC_BIAS);
      default:  bias_val = '0;
    endcase
    acc_d   = base_val + (cmd_i.p_sub ? -p_term : p_term) - bias_val;
    acc_sat = sat32(acc_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      az_q    <= accel_vertical_i;
      roll_q  <= roll_rate_i;
      pitch_q <= pitch_rate_i;
      ws_q    <= wheel_speed_i;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
      case (cmd_i.dest)
        DST_REF:     ref_q     <= acc_sat;
        DST_ACC_ANG: acc_ang_q <= acc_sat;
        DST_INNER:   inner_q   <= acc_sat;
        DST_TILT:    tilt_q    <= acc_sat;
        DST_HEAD:    head_q    <= acc_sat;
        DST_DRIVE:   drive_q   <= acc_sat;
        DST_TURN:    turn_q    <= acc_sat;
        default: ;
      endcase
    end
  end

  // Wheel mixing: the turn drive only enters while the tilt is small.
  always_comb begin
    drv_ext     = AW'(drive_q);
    trn_ext     = AW'(turn_q);
    tilt_in_win = (tilt_q < DW'(K_TILT_WIN)) && (tilt_q > -DW'(K_TILT_WIN));
    if (tilt_in_win) begin
      left_d  = sat32(-drv_ext - trn_ext);
      right_d = sat32(drv_ext - trn_ext);
    end else begin
      left_d  = sat32(-drv_ext);
      right_d = drive_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      left_accel_o       <= left_d;
      right_accel_o      <= right_d;
      drive_positive_o   <= (drive_q > 0);
      tilt_estimate_o    <= tilt_q;
      heading_estimate_o <= head_q;
    end
  end

endmodule

/* hw/rtl/balance_turn_control_step.sv */
// ----------------------------------------------------------------------------
// balance_turn_control_step: one control tick of a two-wheeled balancer
// Complementary tilt filter, heading integrator, speed PD, tilt PID and turn
// PD with saturated wheel acceleration outputs, all in signed Q11.20.
// ----------------------------------------------------------------------------
// Each accepted word carries one tick of sensor data and produces exactly one
// result word. The block works on one tick at a time: the result word becomes
// valid when the output step loads the output register, and the next word is
// taken only after that output step. The twelve products of the tick pass in
// sequence through one shared multiplier, then come an accumulate step, an
// output step and the cycle that takes the next word. A finished result sits
// in the output register until taken; meanwhile the next word is already
// accepted and computed, and only its final output step waits for the
// register to free up. The setpoint registers are written through the plain
// write port and must only change while the block is idle. After reset the
// tilt, heading and speed error history and both setpoints are zero.
module balance_turn_control_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [btcs_pkg::DW-1:0]        cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [btcs_pkg::DW-1:0] accel_vertical_i,
  input  logic signed [btcs_pkg::DW-1:0] roll_rate_i,
  input  logic signed [btcs_pkg::DW-1:0] pitch_rate_i,
  input  logic signed [btcs_pkg::DW-1:0] wheel_speed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [btcs_pkg::DW-1:0] left_accel_o,
  output logic signed [btcs_pkg::DW-1:0] right_accel_o,
  output logic                           drive_positive_o,
  output logic signed [btcs_pkg::DW-1:0] tilt_estimate_o,
  output logic signed [btcs_pkg::DW-1:0] heading_estimate_o
);
  import btcs_pkg::*;

  // Command word from the sequencer; the datapath reports nothing back, since
  // the schedule is fixed and only the handshakes decide when it advances.
  dp_cmd_t cmd;

  btcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  btcs_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .accel_vertical_i   (accel_vertical_i),
    .roll_rate_i        (roll_rate_i),
    .pitch_rate_i       (pitch_rate_i),
    .wheel_speed_i      (wheel_speed_i),
    .left_accel_o       (left_accel_o),
    .right_accel_o      (right_accel_o),
    .drive_positive_o   (drive_positive_o),
    .tilt_estimate_o    (tilt_estimate_o),
    .heading_estimate_o (heading_estimate_o)
  );

endmodule

/* hw/rtl/btcs_checker.sv */
// ----------------------------------------------------------------------------
// btcs_checker: port level checks of the balance and turn control step
// Watches the top level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module btcs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [btcs_pkg::DW-1:0] left_accel_o,
  input logic signed [btcs_pkg::DW-1:0] right_accel_o,
  input logic                           drive_positive_o,
  input logic signed [btcs_pkg::DW-1:0] tilt_estimate_o
);
  import btcs_pkg::*;

  localparam logic signed [DW-1:0] TILT_WIN = DW'(K_TILT_WIN);

  // Once a word is accepted, the block is busy at the first step and at the finish of its schedule.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##1 in_stall_o ##13 in_stall_o)
    else $error("input taken again before the tick finished");

  // A result only appears at the end of a busy period.
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without a tick in progress");

  // Outside the tilt window the right wheel carries the balance drive alone.
  a_drive_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tilt_estimate_o >= TILT_WIN || tilt_estimate_o <= -TILT_WIN)
    |-> drive_positive_o == (right_accel_o > 0))
    else $error("drive direction disagrees with right wheel command");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_accel_o)
      && $stable(right_accel_o) && $stable(tilt_estimate_o))
    else $error("stalled result word changed");

endmodule

bind balance_turn_control_step btcs_checker u_btcs_checker (.*);
